@@ hw/rtl/tlb_pkg.sv @@
// Shared types and constants for the terminal line buffer.
// No dependencies; every other file of the block but tlb_ram imports this package.
package tlb_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RCNT_W  = 7;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COND_W  = 2;

  localparam logic [CHAR_W-1:0] NL_CHAR = 8'h0A;

  // Request codes on the input channel.
  localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POLL = 2'd2;

  // Result kinds on the output channel.
  localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POLL  = 2'd3;

  // Poll condition bits.
  localparam int unsigned COND_READ_BIT  = 0;
  localparam int unsigned COND_WRITE_BIT = 1;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_POLL
  } op_e;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic              is_nl;
    logic [RCNT_W-1:0] cnt;
    logic [COND_W-1:0] cond;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [COND_W-1:0] poll_ready;
    logic              line_ready;
    logic              overflow;
  } rsp_t;

endpackage

@@ hw/rtl/tlb_if.sv @@
// Valid/ready channel interfaces for the request and result streams.
// Depends on tlb_pkg for the field widths.
interface tlb_req_if import tlb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_in;
  logic [RCNT_W-1:0] read_count;
  logic [COND_W-1:0] poll_cond;

  modport source (output valid, req_type, char_in, read_count, poll_cond, input ready);
  modport sink   (input valid, req_type, char_in, read_count, poll_cond, output ready);
endinterface

interface tlb_rsp_if import tlb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [CHAR_W-1:0] out_char;
  logic              last;
  logic [COND_W-1:0] poll_ready;
  logic              line_ready;
  logic              overflow;

  modport source (output valid, result_kind, out_char, last, poll_ready, line_ready,
                  overflow, input ready);
  modport sink   (input valid, result_kind, out_char, last, poll_ready, line_ready,
                  overflow, output ready);
endinterface

@@ hw/rtl/tlb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tlb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/tlb_front.sv @@
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on tlb_pkg and tlb_req_if.
module tlb_front import tlb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlb_req_if.sink   req_i,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  logic      cmd_pop_i
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  cmd_t             q_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  cmd_t             cmd_new;
  logic             is_cmd;
  logic             push;
  logic             pop;

  // Unused request codes are taken and dropped here.
  always_comb begin
    cmd_new.ch    = req_i.char_in;
    cmd_new.is_nl = (req_i.char_in == NL_CHAR);
    cmd_new.cnt   = req_i.read_count;
    cmd_new.cond  = req_i.poll_cond;
    cmd_new.op    = OP_ADD;
    is_cmd        = 1'b1;
    unique case (req_i.req_type)
      REQ_ADD:  cmd_new.op = OP_ADD;
      REQ_READ: cmd_new.op = OP_READ;
      REQ_POLL: cmd_new.op = OP_POLL;
      default:  is_cmd     = 1'b0;
    endcase
  end

  assign req_i.ready = (cnt_q != QCntW'(QDepth));
  assign push        = req_i.valid && req_i.ready && is_cmd;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ hw/rtl/tlb_back.sv @@
// Back end: executes queued requests against the character ring and drives results.
// Depends on tlb_pkg, tlb_rsp_if and tlb_ram.
module tlb_back import tlb_pkg::*; #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  tlb_rsp_if.source rsp_o
);

  localparam int unsigned PtrW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(BUF_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(BUF_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(BUF_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RWAIT,
    S_REMIT
  } state_e;

  state_e            state_q, state_d;
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [CntW-1:0]   nl_q, nl_d;
  logic [RCNT_W-1:0] rem_q, rem_d;
  logic              lim_q, lim_d;
  rsp_t              rsp_q, rsp_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              out_free;
  logic              we;
  logic [CHAR_W-1:0] rd_data;
  logic              stop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  // The read address follows the next head, so the registered read data holds
  // the byte at the head. A read run passes through the wait state S_RWAIT
  // first, which also covers a write to the head slot made by the add just before it.
  tlb_ram #(
    .Width(CHAR_W),
    .Depth(BUF_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(tail_q),
    .wdata_i(cmd_i.ch),
    .raddr_i(head_d),
    .rdata_o(rd_data)
  );

  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    nl_d        = nl_q;
    rem_d       = rem_q;
    lim_d       = lim_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    we          = 1'b0;
    cmd_pop_o   = 1'b0;
    stop        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o        = 1'b1;
          rsp_d.ch         = '0;
          rsp_d.last       = 1'b1;
          rsp_d.poll_ready = '0;
          rsp_d.line_ready = 1'b0;
          rsp_d.overflow   = 1'b0;
          unique case (cmd_i.op)
            OP_ADD: begin
              rsp_valid_d = 1'b1;
              rsp_d.kind  = KIND_ECHO;
              rsp_d.ch    = cmd_i.ch;
              if (fill_q != CntFull) begin
                we               = 1'b1;
                tail_d           = ptr_next(tail_q);
                fill_d           = fill_q + 1'b1;
                nl_d             = nl_q + CntW'(cmd_i.is_nl);
                rsp_d.line_ready = cmd_i.is_nl;
              end else begin
                rsp_d.overflow = 1'b1;
              end
            end
            OP_READ: begin
              if (nl_q == '0) begin
                rsp_valid_d = 1'b1;
                rsp_d.kind  = KIND_EMPTY;
              end else begin
                rem_d   = cmd_i.cnt;
                lim_d   = (cmd_i.cnt != '0);
                state_d = S_RWAIT;
              end
            end
            OP_POLL: begin
              rsp_valid_d                     = 1'b1;
              rsp_d.kind                      = KIND_POLL;
              rsp_d.poll_ready[COND_WRITE_BIT] = cmd_i.cond[COND_WRITE_BIT];
              rsp_d.poll_ready[COND_READ_BIT]  = cmd_i.cond[COND_READ_BIT] && (nl_q != '0);
            end
            default: rsp_valid_d = rsp_valid_q && !rsp_o.ready;
          endcase
        end
      end
      S_RWAIT: begin
        state_d = S_REMIT;
      end
      S_REMIT: begin
        if (out_free) begin
          stop = (rd_data == NL_CHAR) || (lim_q && (rem_q == RCNT_W'(1))) ||
                 (fill_q == CntW'(1));
          rsp_valid_d      = 1'b1;
          rsp_d.kind       = KIND_DATA;
          rsp_d.ch         = rd_data;
          rsp_d.last       = stop;
          rsp_d.poll_ready = '0;
          rsp_d.line_ready = 1'b0;
          rsp_d.overflow   = 1'b0;
          head_d           = ptr_next(head_q);
          fill_d           = fill_q - 1'b1;
          nl_d             = nl_q - CntW'(rd_data == NL_CHAR);
          rem_d            = rem_q - 1'b1;
          state_d          = stop ? S_IDLE : S_REMIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      nl_q        <= '0;
      rem_q       <= '0;
      lim_q       <= 1'b0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      nl_q        <= nl_d;
      rem_q       <= rem_d;
      lim_q       <= lim_d;
      rsp_q       <= rsp_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.result_kind = rsp_q.kind;
  assign rsp_o.out_char    = rsp_q.ch;
  assign rsp_o.last        = rsp_q.last;
  assign rsp_o.poll_ready  = rsp_q.poll_ready;
  assign rsp_o.line_ready  = rsp_q.line_ready;
  assign rsp_o.overflow    = rsp_q.overflow;

endmodule

@@ hw/rtl/tty_line_buffer.sv @@
// Top level of the terminal input line buffer.
// Depends on tlb_pkg, tlb_if, tlb_front, tlb_back and tlb_ram.
//
// Usage:
//   req_i carries requests: add a character, read a line, or poll readiness.
//   rsp_o carries results: one echo per add, one status per poll, and for a
//   read either one empty marker or a run of characters ending in last = 1.
//   A transfer happens on a clock edge where valid and ready are both high.
//   Unused request codes are taken and produce nothing.
// Order and throughput:
//   A request is queued on its transfer and executed by the back end in a
//   later cycle; an echo, empty marker or poll status is then offered from
//   the result register. A read run is offered after the back end takes the
//   read and a wait state covers the registered read port of the character
//   store; it then gives one character per cycle while rsp_o does not stall.
//   Adds and polls sustain one request per cycle while rsp_o does not stall.
// Reset and stalls:
//   Reset empties the store, the two-entry request queue and the result
//   register; no clearing pass is needed. When rsp_o stalls, the result
//   register holds, the back end waits, and the queue keeps taking requests
//   until both of its entries are full.
module tty_line_buffer import tlb_pkg::*; #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlb_req_if.sink   req_i,
  tlb_rsp_if.source rsp_o
);

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  tlb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop)
  );

  tlb_back #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .rsp_o      (rsp_o)
  );

endmodule

@@ hw/rtl/tlb_checker.sv @@
// Port-level checks on the line buffer's result stream, and their binding.
// Depends on tlb_pkg and the tty_line_buffer top level.
module tlb_checker import tlb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [KIND_W-1:0] result_kind,
  input logic [CHAR_W-1:0] out_char,
  input logic              last,
  input logic [COND_W-1:0] poll_ready,
  input logic              line_ready,
  input logic              overflow
);

  // A result held back by the receiver stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  // Only read data can be a non-final result of a run.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (result_kind != KIND_DATA) |-> last)
    else $error("single result without last");

  // A stored line end is echoed as a newline and never together with a drop.
  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && line_ready |->
      (result_kind == KIND_ECHO) && (out_char == NL_CHAR) && !overflow)
    else $error("line_ready on a wrong result");

  // Poll grants appear only on poll status, and status carries no character.
  a_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && ((poll_ready != '0) || (result_kind == KIND_POLL)) |->
      (result_kind == KIND_POLL) && (out_char == '0))
    else $error("poll fields on a wrong result");

endmodule

bind tty_line_buffer tlb_checker u_tlb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rsp_valid  (rsp_o.valid),
  .rsp_ready  (rsp_o.ready),
  .result_kind(rsp_o.result_kind),
  .out_char   (rsp_o.out_char),
  .last       (rsp_o.last),
  .poll_ready (rsp_o.poll_ready),
  .line_ready (rsp_o.line_ready),
  .overflow   (rsp_o.overflow)
);
